// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger at one edge implies the consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rcm4_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm4_pkg
// types and constants of the four-entry repeat offset cache
// ----------------------------------------------------------------------------
package rcm4_pkg;

	localparam int OFFSET_W = 31;
	localparam int NUM_ENTRIES = 4;
	localparam int CFG_INDEX_W = 3;

	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [1:0] slot_t;
	// recency order: slot p names the entry at recency position p
	typedef logic [NUM_ENTRIES-1:0][1:0] order_t;
	typedef logic [NUM_ENTRIES-1:0][OFFSET_W-1:0] entries_t;

	typedef enum logic [1:0] {
		OP_QUERY   = 2'd0,
		OP_USE     = 2'd1,
		OP_INSERT  = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_INIT_A    = 3'd0,
		CFG_INIT_B    = 3'd1,
		CFG_INIT_C    = 3'd2,
		CFG_INIT_D    = 3'd3,
		CFG_SHIFT_INS = 3'd4
	} cfg_index_t;

	localparam order_t ORDER_IDENTITY = 8'he4;
	localparam entries_t ENTRIES_RESET = {31'd16, 31'd12, 31'd8, 31'd4};

	typedef struct packed {
		entries_t init_offset;
		logic     shift_ins;
	} cfg_t;

	typedef struct packed {
		op_t     op;
		slot_t   pos;
		offset_t new_offset;
	} cmd_t;

endpackage

// ----- rtl/core/rcm4_cfg.sv -----
// ----------------------------------------------------------------------------
// rcm4_cfg
// configuration register file: initial offsets and insert mode
// ----------------------------------------------------------------------------
module rcm4_cfg import rcm4_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  offset_t                wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_offset <= ENTRIES_RESET;
			cfg_q.shift_ins   <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_INIT_A:    cfg_q.init_offset[0] <= wr_data;
				CFG_INIT_B:    cfg_q.init_offset[1] <= wr_data;
				CFG_INIT_C:    cfg_q.init_offset[2] <= wr_data;
				CFG_INIT_D:    cfg_q.init_offset[3] <= wr_data;
				CFG_SHIFT_INS: cfg_q.shift_ins <= wr_data[0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/rcm4_core.sv -----
// ----------------------------------------------------------------------------
// rcm4_core
// offset entries and recency order with the registered update and combinational readout
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcm4_core import rcm4_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  cmd_t    cmd,
	input  cfg_t    cfg,
	output offset_t offset
);

	entries_t entries_q;
	order_t   order_q;
	entries_t entries_nxt;
	order_t   order_nxt;
	logic [NUM_ENTRIES-1:0] order_cover;

	always_comb begin
		entries_nxt = entries_q;
		order_nxt   = order_q;
		unique case (cmd.op)
			OP_QUERY: ;
			OP_USE: begin
				// promote position pos, shift the more recent ones back by one
				order_nxt[0] = order_q[cmd.pos];
				for (int p = 1; p < NUM_ENTRIES; p++) begin
					if (2'(p) <= cmd.pos)
						order_nxt[p] = order_q[2'(p - 1)];
				end
			end
			OP_INSERT: begin
				if (cfg.shift_ins) begin
					entries_nxt[order_q[3]] = entries_q[order_q[2]];
					entries_nxt[order_q[2]] = cmd.new_offset;
				end else begin
					entries_nxt[order_q[3]] = cmd.new_offset;
				end
			end
			OP_RESTART: begin
				entries_nxt = cfg.init_offset;
				order_nxt   = ORDER_IDENTITY;
			end
		endcase
		offset = entries_nxt[order_nxt[cmd.pos]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
			order_q   <= ORDER_IDENTITY;
		end else if (step) begin
			entries_q <= entries_nxt;
			order_q   <= order_nxt;
		end
	end

	// every entry must appear exactly once in the order
	always_comb begin
		order_cover = '0;
		for (int p = 0; p < NUM_ENTRIES; p++)
			order_cover[order_q[p]] = 1'b1;
	end

	`ASSERT_ALWAYS(a_order_perm, clk, arst_n, order_cover == {NUM_ENTRIES{1'b1}},
		"recency order is not a permutation")
	`ASSERT_NEXT(a_restart_order, clk, arst_n, step && cmd.op == OP_RESTART,
		order_q == ORDER_IDENTITY, "restart did not restore identity order")
	`ASSERT_NEXT(a_query_holds, clk, arst_n, step && cmd.op == OP_QUERY,
		$stable(order_q) && $stable(entries_q), "query changed cache state")

endmodule

// ----- rtl/core/repeat_offset_cache_mtf4.sv -----
// path: the input register takes the item, then the result register holds the result driven on m_axis
// throughput: one item per cycle while m_axis does not stall, set by the update of entries and recency order
// a stalled m_axis holds the result and backs up into s_axis through the input register
// reset: arst_n clears valids asynchronously and loads offsets 4, 8, 12, 16,
// order 0xe4 and normal insert mode; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
// repeat_offset_cache_mtf4
// four-entry lz repeat offset cache with move-to-front recency order
// ----------------------------------------------------------------------------
module repeat_offset_cache_mtf4 import rcm4_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [39:0]            s_axis_tdata,  // operation, position, new_offset, pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [31:0]            m_axis_tdata,  // offset_at_position, pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [OFFSET_W-1:0]    cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd_s1;
	logic    valid_s1;
	offset_t offset;
	offset_t result_q;
	logic    result_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;

	rcm4_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// item in the input register is processed once the result slot is free
	assign advance       = valid_s1 & (~result_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1.op         <= op_t'(s_axis_tdata[1:0]);
			cmd_s1.pos        <= s_axis_tdata[3:2];
			cmd_s1.new_offset <= s_axis_tdata[34:4];
		end
	end

	rcm4_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.offset (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= offset;
	end

	assign m_axis_tvalid = result_valid_q;
	assign m_axis_tdata  = {1'b0, result_q};

endmodule
